/* sv/nns_pkg.sv */
package nns_pkg;

  localparam int SRC_W   = 10;
  localparam int COL_W   = 9;
  localparam int ROW_W   = 8;
  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 32;
  localparam int PADDR_W = 5;
  localparam int IDX_W   = 2 * SRC_W;
  // divider works two quotient bits per step, so the dividend width is kept even
  localparam int DVD_W   = IDX_W + (IDX_W % 2);
  localparam int DVS_W   = COL_W;

  localparam int DEF_MAX_DEST_WIDTH = 320;
  localparam int DEF_MAX_SOURCE_DIM = 1024;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_SOURCE_WIDTH  = 3'd0;
  localparam reg_idx_t REG_SOURCE_HEIGHT = 3'd1;
  localparam reg_idx_t REG_DEST_WIDTH    = 3'd2;
  localparam reg_idx_t REG_DEST_HEIGHT   = 3'd3;
  localparam reg_idx_t REG_SOURCE_BASE   = 3'd4;

  localparam logic [SRC_W-1:0]  RST_SOURCE_WIDTH  = 10'd320;
  localparam logic [SRC_W-1:0]  RST_SOURCE_HEIGHT = 10'd240;
  localparam logic [COL_W-1:0]  RST_DEST_WIDTH    = 9'd320;
  localparam logic [ROW_W-1:0]  RST_DEST_HEIGHT   = 8'd240;
  localparam logic [ADDR_W-1:0] RST_SOURCE_BASE   = 32'd0;

  typedef struct packed {
    logic [SRC_W-1:0]  source_width;
    logic [SRC_W-1:0]  source_height;
    logic [COL_W-1:0]  dest_width;
    logic [ROW_W-1:0]  dest_height;
    logic [ADDR_W-1:0] source_base;
  } cfg_t;

endpackage

/* sv/nns_cfg.sv */
module nns_cfg
  import nns_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready,
  output cfg_t               cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = cfg_paddr[PADDR_W-1:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SOURCE_WIDTH:  cfg_nxt.source_width  = cfg_pwdata[SRC_W-1:0];
        REG_SOURCE_HEIGHT: cfg_nxt.source_height = cfg_pwdata[SRC_W-1:0];
        REG_DEST_WIDTH:    cfg_nxt.dest_width    = cfg_pwdata[COL_W-1:0];
        REG_DEST_HEIGHT:   cfg_nxt.dest_height   = cfg_pwdata[ROW_W-1:0];
        REG_SOURCE_BASE:   cfg_nxt.source_base   = cfg_pwdata[ADDR_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE_WIDTH:  cfg_prdata = DATA_W'(cfg_r.source_width);
      REG_SOURCE_HEIGHT: cfg_prdata = DATA_W'(cfg_r.source_height);
      REG_DEST_WIDTH:    cfg_prdata = DATA_W'(cfg_r.dest_width);
      REG_DEST_HEIGHT:   cfg_prdata = DATA_W'(cfg_r.dest_height);
      REG_SOURCE_BASE:   cfg_prdata = DATA_W'(cfg_r.source_base);
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.source_width  <= RST_SOURCE_WIDTH;
      cfg_r.source_height <= RST_SOURCE_HEIGHT;
      cfg_r.dest_width    <= RST_DEST_WIDTH;
      cfg_r.dest_height   <= RST_DEST_HEIGHT;
      cfg_r.source_base   <= RST_SOURCE_BASE;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* sv/nns_div.sv */
module nns_div
  import nns_pkg::*;
#(
  parameter int DVD_WIDTH = DVD_W,
  parameter int DVS_WIDTH = DVS_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DVD_WIDTH-1:0] dividend,
  input  logic [DVS_WIDTH-1:0] divisor,
  output logic                 done,
  output logic [DVD_WIDTH-1:0] quotient
);

  localparam int STEPS = DVD_WIDTH / 2;
  localparam int CNT_W = $clog2(STEPS + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS - 1);

  logic [DVD_WIDTH-1:0] dvd_r, dvd_nxt;
  logic [DVS_WIDTH-1:0] dvs_r;
  logic [DVS_WIDTH-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DVS_WIDTH:0]   t1, t2, d1, d2;
  logic [DVS_WIDTH-1:0] r1;
  logic                 ge1, ge2;

  // two restoring steps per cycle; quotient bits shift into the dividend register
  always_comb begin
    t1      = {rem_r, dvd_r[DVD_WIDTH-1]};
    d1      = t1 - {1'b0, dvs_r};
    ge1     = t1 >= {1'b0, dvs_r};
    r1      = ge1 ? d1[DVS_WIDTH-1:0] : t1[DVS_WIDTH-1:0];
    t2      = {r1, dvd_r[DVD_WIDTH-2]};
    d2      = t2 - {1'b0, dvs_r};
    ge2     = t2 >= {1'b0, dvs_r};
    rem_nxt = ge2 ? d2[DVS_WIDTH-1:0] : t2[DVS_WIDTH-1:0];
    dvd_nxt = {dvd_r[DVD_WIDTH-3:0], ge1, ge2};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r != LAST |=> busy_r || $past(start))
    else $error("divider stopped early");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= LAST)
    else $error("divider step count out of range");

endmodule

/* sv/nearest_neighbour_scale_addresser_top.sv */
// Channel   Ports                                       Direction
// in        in_valid, in_ready, in_restart              beat in
// out       out_valid, out_ready, out_byte_address,     beat out
//           out_col, out_row, out_row_end, out_frame_end
// cfg       cfg_psel/penable/pwrite/paddr/pwdata,       APB register access
//           cfg_prdata, cfg_pready
//
// Each beat, from accept to the next accept, runs two 20-bit divides on one shared
// two-bits-per-cycle divider plus setup, index multiply and address add. The
// multiplier is shared too.
// Reset is synchronous, active low; it restores the register defaults and pixel (0,0).
// A stalled output holds the finished beat; the next beat may be taken meanwhile and
// waits only at the final load if the output is still full.
module nearest_neighbour_scale_addresser_top
  import nns_pkg::*;
#(
  parameter int MAX_DEST_WIDTH = DEF_MAX_DEST_WIDTH,
  parameter int MAX_SOURCE_DIM = DEF_MAX_SOURCE_DIM
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [ADDR_W-1:0]  out_byte_address,
  output logic [COL_W-1:0]   out_col,
  output logic [ROW_W-1:0]   out_row,
  output logic               out_row_end,
  output logic               out_frame_end,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0]  cfg_pwdata,
  output logic [DATA_W-1:0]  cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_XSTART = 7'b0000010,
    S_XDIV   = 7'b0000100,
    S_YSTART = 7'b0001000,
    S_YDIV   = 7'b0010000,
    S_MUL    = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  cfg_t cfg;

  nns_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // effective sizes
  logic [COL_W-1:0] dw_eff;
  logic [ROW_W-1:0] dh_eff;
  logic [SRC_W-1:0] sw_eff, sh_eff;

  always_comb begin
    if (cfg.dest_width == '0) begin
      dw_eff = COL_W'(1);
    end else if (32'(cfg.dest_width) > MAX_DEST_WIDTH) begin
      dw_eff = COL_W'(MAX_DEST_WIDTH);
    end else begin
      dw_eff = cfg.dest_width;
    end
    dh_eff = (cfg.dest_height == '0) ? ROW_W'(1) : cfg.dest_height;
    sw_eff = (32'(cfg.source_width) > MAX_SOURCE_DIM) ? SRC_W'(MAX_SOURCE_DIM)
                                                      : cfg.source_width;
    sh_eff = (32'(cfg.source_height) > MAX_SOURCE_DIM) ? SRC_W'(MAX_SOURCE_DIM)
                                                       : cfg.source_height;
  end

  state_t            state_r, state_nxt;
  logic [COL_W-1:0]  next_col_r, next_col_nxt;
  logic [ROW_W-1:0]  next_row_r, next_row_nxt;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic              rend_r, fend_r;
  logic [SRC_W-1:0]  sx_r, sy_r;
  logic [IDX_W-1:0]  idx_r;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [COL_W-1:0]  out_col_r;
  logic [ROW_W-1:0]  out_row_r;
  logic              out_rend_r, out_fend_r;

  logic              in_acc;
  logic              out_load;

  // position of the pixel being taken
  logic [COL_W-1:0]  c0, c1;
  logic [ROW_W-1:0]  r0, r1, r2;
  logic              wrap, rend, fend;

  always_comb begin
    c0   = in_restart ? '0 : next_col_r;
    r0   = in_restart ? '0 : next_row_r;
    wrap = c0 >= dw_eff;
    c1   = wrap ? '0 : c0;
    r1   = wrap ? r0 + 1'b1 : r0;
    r2   = (r1 >= dh_eff) ? '0 : r1;
    rend = c1 == dw_eff - 1'b1;
    fend = rend && (r2 == dh_eff - 1'b1);
  end

  always_comb begin
    next_col_nxt = next_col_r;
    next_row_nxt = next_row_r;
    if (in_acc) begin
      if (fend) begin
        next_col_nxt = '0;
        next_row_nxt = '0;
      end else if (rend) begin
        next_col_nxt = '0;
        next_row_nxt = r2 + 1'b1;
      end else begin
        next_col_nxt = c1 + 1'b1;
        next_row_nxt = r2;
      end
    end
  end

  // shared multiplier: col*sw, row*sh, then sy*sw
  logic [SRC_W-1:0] mul_a, mul_b;
  logic [IDX_W-1:0] prod;

  always_comb begin
    case (state_r)
      S_XSTART: begin
        mul_a = SRC_W'(col_r);
        mul_b = sw_eff;
      end
      S_YSTART: begin
        mul_a = SRC_W'(row_r);
        mul_b = sh_eff;
      end
      default: begin
        mul_a = sy_r;
        mul_b = sw_eff;
      end
    endcase
  end

  assign prod = IDX_W'(mul_a) * IDX_W'(mul_b);

  logic             div_start, div_done;
  logic [DVD_W-1:0] div_q;
  logic [DVS_W-1:0] div_dvs;

  assign div_start = (state_r == S_XSTART) || (state_r == S_YSTART);
  assign div_dvs   = (state_r == S_XSTART) ? dw_eff : DVS_W'(dh_eff);

  nns_div #(
    .DVD_WIDTH (DVD_W),
    .DVS_WIDTH (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DVD_W'(prod)),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_XSTART;
      S_XSTART: state_nxt = S_XDIV;
      S_XDIV:   if (div_done) state_nxt = S_YSTART;
      S_YSTART: state_nxt = S_YDIV;
      S_YDIV:   if (div_done) state_nxt = S_MUL;
      S_MUL:    state_nxt = S_OUT;
      S_OUT:    if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_col_r  <= '0;
      next_row_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_col_r  <= next_col_nxt;
      next_row_r  <= next_row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      col_r  <= c1;
      row_r  <= r2;
      rend_r <= rend;
      fend_r <= fend;
    end
    if (state_r == S_XDIV && div_done) begin
      sx_r <= div_q[SRC_W-1:0];
    end
    if (state_r == S_YDIV && div_done) begin
      sy_r <= div_q[SRC_W-1:0];
    end
    if (state_r == S_MUL) begin
      idx_r <= prod + IDX_W'(sx_r);
    end
    if (out_load) begin
      out_addr_r <= cfg.source_base + ADDR_W'({idx_r, 1'b0});
      out_col_r  <= col_r;
      out_row_r  <= row_r;
      out_rend_r <= rend_r;
      out_fend_r <= fend_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte_address = out_addr_r;
  assign out_col          = out_col_r;
  assign out_row          = out_row_r;
  assign out_row_end      = out_rend_r;
  assign out_frame_end    = out_fend_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_XSTART)
    else $error("accepted beat did not start the sequence");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_XDIV || state_r == S_YDIV))
    else $error("divider finished outside a wait state");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fend_r |-> out_rend_r)
    else $error("frame end without row end");

  a_col_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_col_r < dw_eff && out_row_r < dh_eff)
    else $error("emitted pixel outside destination window");

endmodule

/* tb/tb_nearest_neighbour_scale_addresser_top.sv */
module tb_nearest_neighbour_scale_addresser_top;
  import nns_pkg::*;

  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 1350;
  localparam int MAX_PRINTED  = 200;

  typedef struct packed {
    logic [ADDR_W-1:0] byte_address;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              row_end;
    logic              frame_end;
  } pixel_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_restart = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [ADDR_W-1:0]  out_byte_address;
  logic [COL_W-1:0]   out_col;
  logic [ROW_W-1:0]   out_row;
  logic               out_row_end;
  logic               out_frame_end;
  logic               cfg_psel = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0] cfg_paddr = '0;
  logic [DATA_W-1:0]  cfg_pwdata = '0;
  logic [DATA_W-1:0]  cfg_prdata;
  logic               cfg_pready;

  // predictor state: register copies and the walk position
  cfg_t               frame_regs = '{RST_SOURCE_WIDTH, RST_SOURCE_HEIGHT, RST_DEST_WIDTH,
                                     RST_DEST_HEIGHT, RST_SOURCE_BASE};
  int unsigned        walk_col = 0;
  int unsigned        walk_row = 0;

  pixel_t             expected_pixels[$];
  pixel_t             checked_pixel;
  int                 mismatch_count = 0;
  int                 cycle_count = 0;
  bit                 sender_gaps_on = 1'b1;
  bit                 receiver_stalls_on = 1'b1;
  int                 hold_off_cycles = 0;

  nearest_neighbour_scale_addresser_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_restart       (in_restart),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte_address (out_byte_address),
    .out_col          (out_col),
    .out_row          (out_row),
    .out_row_end      (out_row_end),
    .out_frame_end    (out_frame_end),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Next pixel of the raster walk and its source address; advances the walk.
  function automatic pixel_t walk_pixel(input logic restart);
    int unsigned     dw, dh, sw, sh, col, row;
    longint unsigned sx, sy;
    pixel_t          px;
    dw = frame_regs.dest_width;
    if (dw == 0) dw = 1;
    else if (dw > DEF_MAX_DEST_WIDTH) dw = DEF_MAX_DEST_WIDTH;
    dh = frame_regs.dest_height;
    if (dh == 0) dh = 1;
    sw = frame_regs.source_width;
    if (sw > DEF_MAX_SOURCE_DIM) sw = DEF_MAX_SOURCE_DIM;
    sh = frame_regs.source_height;
    if (sh > DEF_MAX_SOURCE_DIM) sh = DEF_MAX_SOURCE_DIM;
    col = walk_col;
    row = walk_row;
    if (restart) begin
      col = 0;
      row = 0;
    end
    // window shrank under a stored position
    if (col >= dw) begin
      col = 0;
      row = (row + 1) & 32'hFF;
    end
    if (row >= dh) row = 0;
    sx = (64'(col) * sw) / dw;
    sy = (64'(row) * sh) / dh;
    px.byte_address = ADDR_W'(64'(frame_regs.source_base) + 2 * (sy * sw + sx));
    px.col          = COL_W'(col);
    px.row          = ROW_W'(row);
    px.row_end      = (col + 1 == dw);
    px.frame_end    = px.row_end && (row + 1 == dh);
    if (px.frame_end) begin
      walk_col = 0;
      walk_row = 0;
    end else if (px.row_end) begin
      walk_col = 0;
      walk_row = (row + 1) & 32'hFF;
    end else begin
      walk_col = (col + 1) & 32'h1FF;
      walk_row = row;
    end
    return px;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED)
      $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)",
               what, got, want, cycle_count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("beat with nothing expected", out_byte_address, 0);
      end else begin
        checked_pixel = expected_pixels.pop_front();
        if (out_byte_address !== checked_pixel.byte_address)
          report_mismatch("byte_address", out_byte_address, checked_pixel.byte_address);
        if (out_col !== checked_pixel.col)
          report_mismatch("col", 32'(out_col), 32'(checked_pixel.col));
        if (out_row !== checked_pixel.row)
          report_mismatch("row", 32'(out_row), 32'(checked_pixel.row));
        if (out_row_end !== checked_pixel.row_end)
          report_mismatch("row_end", 32'(out_row_end), 32'(checked_pixel.row_end));
        if (out_frame_end !== checked_pixel.frame_end)
          report_mismatch("frame_end", 32'(out_frame_end), 32'(checked_pixel.frame_end));
      end
    end
  end

  // result side: random stall per beat, plus a long hold-off on request
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end
      stall = receiver_stalls_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_pixel(input logic restart);
    int gap;
    gap = sender_gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_pixels.push_back(walk_pixel(restart));
  endtask

  task automatic drain_pixels();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= PADDR_W'(idx) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_SOURCE_WIDTH:  frame_regs.source_width  = value[SRC_W-1:0];
      REG_SOURCE_HEIGHT: frame_regs.source_height = value[SRC_W-1:0];
      REG_DEST_WIDTH:    frame_regs.dest_width    = value[COL_W-1:0];
      REG_DEST_HEIGHT:   frame_regs.dest_height   = value[ROW_W-1:0];
      REG_SOURCE_BASE:   frame_regs.source_base   = value[ADDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [SRC_W-1:0] sw, input logic [SRC_W-1:0] sh,
                           input logic [COL_W-1:0] dw, input logic [ROW_W-1:0] dh,
                           input logic [ADDR_W-1:0] base);
    write_reg(REG_SOURCE_WIDTH, DATA_W'(sw));
    write_reg(REG_SOURCE_HEIGHT, DATA_W'(sh));
    write_reg(REG_DEST_WIDTH, DATA_W'(dw));
    write_reg(REG_DEST_HEIGHT, DATA_W'(dh));
    write_reg(REG_SOURCE_BASE, base);
  endtask

  function automatic logic [SRC_W-1:0] random_source_dim();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 10'd1023;
      2:       return 10'd1;
      default: return SRC_W'($urandom_range(1, 1023));
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_pixel(1'b0);
    send_pixel(1'b0);
    send_pixel(1'b1);
    drain_pixels();
  endtask

  // zero destination sizes act as one: every beat ends row and frame
  task automatic test_zero_dest();
    set_frame(10'd320, 10'd240, 9'd0, 8'd0, 32'h0000_1000);
    send_pixel(1'b0);
    send_pixel(1'b1);
    drain_pixels();
  endtask

  task automatic test_wide_dest();
    set_frame(10'd1023, 10'd1023, 9'd511, 8'd255, 32'h8000_0000);
    send_pixel(1'b1);
    send_pixel(1'b0);
    drain_pixels();
  endtask

  task automatic test_zero_source();
    set_frame(10'd0, 10'd0, 9'd5, 8'd3, 32'hFFFF_FFFF);
    send_pixel(1'b1);
    send_pixel(1'b0);
    drain_pixels();
    set_frame(10'd0, 10'd1023, 9'd2, 8'd3, 32'h1234_5678);
    send_pixel(1'b0);
    send_pixel(1'b0);
    drain_pixels();
  endtask

  task automatic test_address_wrap();
    set_frame(10'd1023, 10'd1023, 9'd1, 8'd2, 32'hFFFF_FFF0);
    send_pixel(1'b1);
    send_pixel(1'b0);
    drain_pixels();
  endtask

  // sizes shrink under the stored position, column then row
  task automatic test_outside_window();
    set_frame(10'd100, 10'd100, 9'd16, 8'd8, 32'h0);
    send_pixel(1'b1);
    repeat (5) send_pixel(1'b0);
    drain_pixels();
    write_reg(REG_DEST_WIDTH, 4);
    send_pixel(1'b0);
    drain_pixels();
    set_frame(10'd100, 10'd100, 9'd1, 8'd16, 32'h0);
    send_pixel(1'b1);
    repeat (5) send_pixel(1'b0);
    drain_pixels();
    write_reg(REG_DEST_HEIGHT, 3);
    send_pixel(1'b0);
    drain_pixels();
  endtask

  task automatic test_full_row();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b1;
    set_frame(10'd1023, 10'd1023, 9'd320, 8'd1, $urandom);
    send_pixel(1'b1);
    repeat (329) send_pixel(1'b0);
    drain_pixels();
  endtask

  task automatic test_tall_column();
    sender_gaps_on     = 1'b1;
    receiver_stalls_on = 1'b0;
    set_frame(10'd7, 10'd1023, 9'd1, 8'd255, $urandom);
    send_pixel(1'b1);
    repeat (259) send_pixel(1'b0);
    drain_pixels();
  endtask

  // receiver holds off while beats keep coming back to back
  task automatic test_backpressure();
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    set_frame(10'd64, 10'd48, 9'd4, 8'd3, 32'h0010_0000);
    hold_off_cycles = 300;
    send_pixel(1'b1);
    repeat (11) send_pixel(1'b0);
    drain_pixels();
  endtask

  task automatic test_random_frames();
    int   sent, burst, k;
    bit   noisy;
    logic restart;
    logic [COL_W-1:0] dw;
    logic [ROW_W-1:0] dh;
    logic [ADDR_W-1:0] base;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain_pixels();
      case ($urandom_range(0, 9))
        0:       dw = '0;
        1:       dw = COL_W'($urandom_range(321, 511));
        2:       dw = 9'd320;
        default: dw = COL_W'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0:       dh = '0;
        1:       dh = 8'd255;
        2:       dh = ROW_W'($urandom_range(13, 254));
        default: dh = ROW_W'($urandom_range(1, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       base = '0;
        1:       base = '1;
        default: base = $urandom;
      endcase
      set_frame(random_source_dim(), random_source_dim(), dw, dh, base);
      sender_gaps_on     = ($urandom_range(0, 3) != 0);
      receiver_stalls_on = ($urandom_range(0, 3) != 0);
      noisy = ($urandom_range(0, 4) == 0);
      burst = $urandom_range(20, 120);
      for (k = 0; k < burst; k++) begin
        // mostly clean walks; a frame left open carries into the next sizes
        if (k == 0) restart = ($urandom_range(0, 3) != 0);
        else if (noisy) restart = ($urandom_range(0, 2) == 0);
        else restart = ($urandom_range(0, 39) == 0);
        send_pixel(restart);
      end
      sent += burst;
    end
    drain_pixels();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_zero_dest();
    test_wide_dest();
    test_zero_source();
    test_address_wrap();
    test_outside_window();
    test_backpressure();
    test_full_row();
    test_tall_column();
    test_random_frames();
    drain_pixels();
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/nns_pkg.sv
sv/nns_cfg.sv
sv/nns_div.sv
sv/nearest_neighbour_scale_addresser_top.sv
tb/tb_nearest_neighbour_scale_addresser_top.sv
